// ===== rtl/core/ook_tx_pkg.sv =====
// ----------------------------------------------------------------------------
// ook_tx_pkg
// Shared types and constants for the OOK remote-frame transmitter.
// ----------------------------------------------------------------------------
package ook_tx_pkg;

  localparam int unsigned TickW   = 6;
  localparam int unsigned FrameW  = 32;
  localparam int unsigned PosW    = 6;
  localparam int unsigned RepeatW = 8;
  localparam int unsigned EmitW   = 26;
  localparam int unsigned UnitW   = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_SHORT_LOW = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_LOW  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SYNC_LOW  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_PAUSE_LOW = 2'd3;

  localparam logic [TickW-1:0] SHORT_LOW_RST = 6'd1;
  localparam logic [TickW-1:0] LONG_LOW_RST  = 6'd6;
  localparam logic [TickW-1:0] SYNC_LOW_RST  = 6'd10;
  localparam logic [TickW-1:0] PAUSE_LOW_RST = 6'd41;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_SYNC  = 4'b0010,
    PH_BITS  = 4'b0100,
    PH_PAUSE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [TickW-1:0] short_low_ticks;
    logic [TickW-1:0] long_low_ticks;
    logic [TickW-1:0] sync_low_ticks;
    logic [TickW-1:0] pause_low_ticks;
  } cfg_t;

  typedef struct packed {
    logic               mode;
    logic [EmitW-1:0]   emitter_id;
    logic               group_flag;
    logic               switch_on;
    logic [UnitW-1:0]   unit_code;
    logic [RepeatW-1:0] repeat_count;
  } item_t;

  typedef struct packed {
    logic busy_res;
    logic pin_level;
  } result_t;

endpackage

// ===== rtl/core/ook_tx_seq.sv =====
// ----------------------------------------------------------------------------
// ook_tx_seq
// Frame sequencer: frame register, segment counters and line level.
// Each accepted item updates the state; the result is the
// state after the item.
// ----------------------------------------------------------------------------
module ook_tx_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  ook_tx_pkg::item_t   item,
  input  ook_tx_pkg::cfg_t    cfg,
  output ook_tx_pkg::result_t res
);

  logic [ook_tx_pkg::FrameW-1:0]  frame_bits, frame_bits_next;
  logic [ook_tx_pkg::PosW-1:0]    bit_position, bit_position_next;
  logic                           second_half, second_half_next;
  logic                           high_left, high_left_next;
  logic [ook_tx_pkg::TickW-1:0]   low_left, low_left_next;
  logic [ook_tx_pkg::RepeatW-1:0] repeats_left, repeats_left_next;
  ook_tx_pkg::phase_t             phase, phase_next;
  logic                           line_level, line_level_next;

  logic                           seg_end;
  logic                           done;
  logic                           sym_bit;
  logic [4:0]                     sym_idx;

  assign seg_end = !high_left && (low_left == '0);

  always_comb begin
    frame_bits_next   = frame_bits;
    bit_position_next = bit_position;
    second_half_next  = second_half;
    high_left_next    = high_left;
    low_left_next     = low_left;
    repeats_left_next = repeats_left;
    phase_next        = phase;
    line_level_next   = line_level;
    done              = 1'b0;
    sym_idx           = 5'd0;
    sym_bit           = 1'b0;

    if (item.mode) begin
      frame_bits_next   = {item.emitter_id, item.group_flag, item.switch_on, item.unit_code};
      repeats_left_next = (item.repeat_count == '0) ? 8'd1 : item.repeat_count;
      phase_next        = ook_tx_pkg::PH_SYNC;
      bit_position_next = '0;
      second_half_next  = 1'b0;
      high_left_next    = 1'b1;
      low_left_next     = cfg.sync_low_ticks;
    end else if (phase != ook_tx_pkg::PH_IDLE) begin
      if (seg_end) begin
        high_left_next = 1'b1;
        case (phase)
          ook_tx_pkg::PH_SYNC: begin
            phase_next        = ook_tx_pkg::PH_BITS;
            bit_position_next = '0;
            second_half_next  = 1'b0;
          end
          ook_tx_pkg::PH_BITS: begin
            if (second_half) begin
              second_half_next  = 1'b0;
              bit_position_next = bit_position + 6'd1;
            end else begin
              second_half_next = 1'b1;
            end
          end
          ook_tx_pkg::PH_PAUSE: begin
            repeats_left_next = repeats_left - 8'd1;
            if (repeats_left_next != '0) begin
              phase_next        = ook_tx_pkg::PH_SYNC;
              bit_position_next = '0;
              second_half_next  = 1'b0;
              low_left_next     = cfg.sync_low_ticks;
            end else begin
              done = 1'b1;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase

        if (phase_next == ook_tx_pkg::PH_BITS) begin
          if (bit_position_next[ook_tx_pkg::PosW-1]) begin
            phase_next    = ook_tx_pkg::PH_PAUSE;
            low_left_next = cfg.pause_low_ticks;
          end else begin
            sym_idx       = 5'd31 - bit_position_next[4:0];
            sym_bit       = frame_bits[sym_idx] ^ second_half_next;
            low_left_next = sym_bit ? cfg.long_low_ticks : cfg.short_low_ticks;
          end
        end
      end

      if (done) begin
        phase_next      = ook_tx_pkg::PH_IDLE;
        line_level_next = 1'b0;
        high_left_next  = 1'b0;
        low_left_next   = '0;
      end else if (high_left_next) begin
        line_level_next = 1'b1;
        high_left_next  = 1'b0;
      end else begin
        line_level_next = 1'b0;
        low_left_next   = low_left_next - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bits   <= '0;
      bit_position <= '0;
      second_half  <= 1'b0;
      high_left    <= 1'b0;
      low_left     <= '0;
      repeats_left <= '0;
      phase        <= ook_tx_pkg::PH_IDLE;
      line_level   <= 1'b0;
    end else if (step) begin
      frame_bits   <= frame_bits_next;
      bit_position <= bit_position_next;
      second_half  <= second_half_next;
      high_left    <= high_left_next;
      low_left     <= low_left_next;
      repeats_left <= repeats_left_next;
      phase        <= phase_next;
      line_level   <= line_level_next;
    end
  end

  assign res.pin_level = line_level_next;
  assign res.busy_res  = (phase_next != ook_tx_pkg::PH_IDLE);

`ifndef SYNTHESIS
  a_idle_low: assert property (@(posedge clk) disable iff (rst)
    (phase == ook_tx_pkg::PH_IDLE) |-> !line_level)
    else $error("line high while idle");

  a_bits_pos: assert property (@(posedge clk) disable iff (rst)
    (phase == ook_tx_pkg::PH_BITS) |-> !bit_position[ook_tx_pkg::PosW-1])
    else $error("bit position past frame end in data phase");

  a_busy_rep: assert property (@(posedge clk) disable iff (rst)
    (phase != ook_tx_pkg::PH_IDLE) |-> (repeats_left != '0))
    else $error("busy with no repeats left");
`endif

endmodule

// ===== rtl/core/ook_remote_frame_transmitter.sv =====
// ----------------------------------------------------------------------------
// ook_remote_frame_transmitter
// Tick-driven OOK remote-control frame transmitter with skid output stage.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream: one item per transfer. s_tuser is the mode (0 = one time-base
//   tick, 1 = start a transmission with the frame fields in s_tdata).
//   m_* stream: one result per input item, line level and busy flag.
//   cfg_*: register writes (index 0..3: short, long, sync, pause low ticks),
//   always ready, to be done while no item is in flight.
// Output: each result is registered in the output stage, or in the skid register while m_tready is low.
// Throughput: one item per clock while s_tready is high; the sequencer state updates
//   between the input transfer and the result register.
// Reset: line low, idle, timing registers back to 1/6/10/41 ticks.
// Stall: a skid register holds one extra result, so one more item is taken
//   while m_tready is low; s_tready then drops until the stage drains.
// ----------------------------------------------------------------------------
module ook_remote_frame_transmitter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [25:0] emitter_id, [26] group_flag, [27] switch_on, [31:28] unit_code,
  // [39:32] repeat_count
  input  logic [39:0]                      s_tdata,
  // [0] mode
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] pin_level, [1] busy_res, [7:2] zero
  output logic [7:0]                       m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ook_tx_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ook_tx_pkg::TickW-1:0]     cfg_data
);

  ook_tx_pkg::cfg_t    cfg;
  ook_tx_pkg::item_t   item;
  ook_tx_pkg::result_t res;
  ook_tx_pkg::result_t out_res;
  ook_tx_pkg::result_t skid_res;
  logic                skid_valid;
  logic                s_xfer;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_low_ticks <= ook_tx_pkg::SHORT_LOW_RST;
      cfg.long_low_ticks  <= ook_tx_pkg::LONG_LOW_RST;
      cfg.sync_low_ticks  <= ook_tx_pkg::SYNC_LOW_RST;
      cfg.pause_low_ticks <= ook_tx_pkg::PAUSE_LOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ook_tx_pkg::REG_SHORT_LOW: cfg.short_low_ticks <= cfg_data;
        ook_tx_pkg::REG_LONG_LOW:  cfg.long_low_ticks  <= cfg_data;
        ook_tx_pkg::REG_SYNC_LOW:  cfg.sync_low_ticks  <= cfg_data;
        ook_tx_pkg::REG_PAUSE_LOW: cfg.pause_low_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign item.mode         = s_tuser;
  assign item.emitter_id   = s_tdata[25:0];
  assign item.group_flag   = s_tdata[26];
  assign item.switch_on    = s_tdata[27];
  assign item.unit_code    = s_tdata[31:28];
  assign item.repeat_count = s_tdata[39:32];

  assign s_tready = !skid_valid;
  assign s_xfer   = s_tvalid && s_tready;

  ook_tx_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (s_xfer),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid   <= skid_valid || s_xfer;
      skid_valid <= 1'b0;
    end else if (s_xfer) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (s_xfer) begin
      skid_res <= res;
    end
  end

  assign m_tdata = {6'd0, out_res.busy_res, out_res.pin_level};

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid holds a result with output stage empty");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && m_tvalid && !m_tready) |=> skid_valid)
    else $error("transfer during output stall not captured in skid");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && m_tready) |=> (m_tvalid && !skid_valid))
    else $error("skid result not moved to output stage");
`endif

endmodule
